### src/rms_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rms_pkg: shared types and constants of the running median store
// Word layouts of the three channels, the per-cell control group and the
// default sizing of the sorted store.
// ----------------------------------------------------------------------------
package rms_pkg;

  localparam int DataW              = 32;
  localparam int CountW             = 7;
  localparam int DefaultStoreDepth  = 64;
  localparam logic signed [DataW-1:0] SeedReset = 32'sd34;

  // input word: one sample to insert
  typedef struct packed {
    logic signed [DataW-1:0] sample_value;
  } in_word_t;

  // result word: median and fill state after one sample
  typedef struct packed {
    logic signed [DataW-1:0] median_value;
    logic [CountW-1:0]       held_count;
    logic                    dropped;
  } out_word_t;

  // configuration word: new seed, restarts the store
  typedef struct packed {
    logic signed [DataW-1:0] seed_value;
  } cfg_word_t;

  // control broadcast to every cell of the chain
  typedef struct packed {
    logic insert;
    logic restart;
  } cell_ctl_t;

endpackage : rms_pkg
`default_nettype wire

### src/rms_chan_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rms_chan_if: valid/ready channel
// Carries one word per handshake; the word type is set per instance.
// ----------------------------------------------------------------------------
interface rms_chan_if #(
  parameter type word_t = logic
) ();
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface : rms_chan_if
`default_nettype wire

### src/rms_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rms_cell: one slot of the sorted insertion chain
// Holds one entry and its occupied flag. On insert, an entry greater than the
// sample moves one slot right; the first slot holding a larger entry (or, if
// there is none, the first empty slot) takes the sample.
// ----------------------------------------------------------------------------
module rms_cell #(
  parameter bit IS_HEAD = 1'b0
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire rms_pkg::cell_ctl_t                    ctl,
  input  wire logic signed [rms_pkg::DataW-1:0]      sample,
  input  wire logic signed [rms_pkg::DataW-1:0]      seed,
  input  wire logic signed [rms_pkg::DataW-1:0]      left_value,
  input  wire logic                                  left_gt,
  input  wire logic                                  left_valid,
  output logic signed [rms_pkg::DataW-1:0]           value,
  output logic                                       gt,
  output logic                                       valid
);
  import rms_pkg::*;

  logic signed [DataW-1:0] value_r;
  logic                    valid_r;
  logic                    take;

  // compare against the sample and decide whether this slot changes
  assign gt    = valid_r && (value_r > sample);
  assign take  = gt || (!valid_r && left_valid);
  assign value = value_r;
  assign valid = valid_r;

  // occupied flag: head is always occupied, the rest fill from the left
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= IS_HEAD;
    end else if (ctl.restart) begin
      valid_r <= IS_HEAD;
    end else if (ctl.insert) begin
      valid_r <= valid_r | left_valid;
    end
  end

  // entry: head loads seed on restart, shift or take sample on insert
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      if (IS_HEAD) begin
        value_r <= SeedReset;
      end
    end else if (ctl.restart) begin
      if (IS_HEAD) begin
        value_r <= seed;
      end
    end else if (ctl.insert && take) begin
      value_r <= left_gt ? left_value : sample;
    end
  end

endmodule : rms_cell
`default_nettype wire

### src/rms_median.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rms_median: median select and halving
// Picks the two middle entries (the same one for an odd count), adds them at
// 33 bits and halves, rounding toward zero.
// ----------------------------------------------------------------------------
module rms_median #(
  parameter int STORE_DEPTH = rms_pkg::DefaultStoreDepth
) (
  input  wire logic signed [rms_pkg::DataW-1:0]        entries [STORE_DEPTH],
  input  wire logic [$clog2(STORE_DEPTH+1)-1:0]        count,
  output logic signed [rms_pkg::DataW-1:0]             median
);
  import rms_pkg::*;

  localparam int CW = $clog2(STORE_DEPTH + 1);
  localparam int IW = $clog2(STORE_DEPTH);

  logic [CW-1:0]           count_m1;
  logic [CW-1:0]           lo_pos;
  logic [CW-1:0]           hi_pos;
  logic [IW-1:0]           lo_idx;
  logic [IW-1:0]           hi_idx;
  logic signed [DataW-1:0] lo_val;
  logic signed [DataW-1:0] hi_val;
  logic [DataW:0]          sum;
  logic [DataW:0]          sum_adj;

  // middle positions: (count-1)/2 and count/2
  assign count_m1 = count - CW'(1);
  assign lo_pos   = count_m1 >> 1;
  assign hi_pos   = count >> 1;
  assign lo_idx   = lo_pos[IW-1:0];
  assign hi_idx   = hi_pos[IW-1:0];
  assign lo_val   = entries[lo_idx];
  assign hi_val   = entries[hi_idx];

  // add sign-extended, bias negative sums by one, then drop the low bit
  assign sum     = {lo_val[DataW-1], lo_val} + {hi_val[DataW-1], hi_val};
  assign sum_adj = sum + {{DataW{1'b0}}, sum[DataW]};
  assign median  = sum_adj[DataW:1];

endmodule : rms_median
`default_nettype wire

### src/running_median_sorted_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// running_median_sorted_store: running median over a sorted insertion chain
//
// Each input word carries one signed sample. It is inserted into a store kept
// in ascending order by a row of STORE_DEPTH compare-and-shift cells, and one
// result word returns the median of all held values, the held count and a
// drop flag (set when the store was full and the sample was discarded).
// The sample is inserted at the accepting edge; the median of the updated
// store is then selected and halved and registered into the output once the
// output register is free, which makes the result word valid. No new word is
// taken while that median step is pending: the insert step is followed by
// the median select-and-add step. A new word is accepted while a
// finished result still waits; when the receiver stalls, at most one more
// word is taken and its median step holds until the output register frees up.
// Reset leaves the store with one entry, the seed 34. A configuration write
// (taken while no median step is pending, ahead of any offered input word)
// sets a new seed and restarts the store to that single entry.
// ----------------------------------------------------------------------------
module running_median_sorted_store #(
  parameter int STORE_DEPTH = rms_pkg::DefaultStoreDepth
) (
  input  wire logic clk,
  input  wire logic rst_n,
  rms_chan_if.sink   in_chan,
  rms_chan_if.source out_chan,
  rms_chan_if.sink   cfg_chan
);
  import rms_pkg::*;

  localparam int CW = $clog2(STORE_DEPTH + 1);

  logic                    in_fire;
  logic                    out_fire;
  logic                    cfg_fire;
  logic                    full;
  logic                    out_load;
  cell_ctl_t               ctl;
  logic [CW-1:0]           count_r;
  logic                    pend_r;
  logic                    drop_r;
  logic                    out_valid_r;
  out_word_t               out_word_r;
  logic signed [DataW-1:0] cell_value [STORE_DEPTH];
  logic                    cell_gt    [STORE_DEPTH];
  logic                    cell_valid [STORE_DEPTH];
  logic signed [DataW-1:0] median;
  logic [CW+CountW-1:0]    count_ext;

  // handshakes; an offered configuration word holds off the input
  assign in_chan.ready  = !pend_r && !cfg_chan.valid;
  assign cfg_chan.ready = !pend_r;
  assign in_fire        = in_chan.valid && in_chan.ready;
  assign cfg_fire       = cfg_chan.valid && cfg_chan.ready;
  assign out_fire       = out_valid_r && out_chan.ready;
  assign full           = (count_r == CW'(STORE_DEPTH));
  assign out_load       = pend_r && (!out_valid_r || out_chan.ready);

  assign ctl.restart = cfg_fire;
  assign ctl.insert  = in_fire && !full && !cfg_fire;

  // insertion chain
  for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      rms_cell #(.IS_HEAD(1'b1)) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .sample     (in_chan.data.sample_value),
        .seed       (cfg_chan.data.seed_value),
        .left_value (in_chan.data.sample_value),
        .left_gt    (1'b0),
        .left_valid (1'b1),
        .value      (cell_value[i]),
        .gt         (cell_gt[i]),
        .valid      (cell_valid[i])
      );
    end else begin : g_body
      rms_cell #(.IS_HEAD(1'b0)) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .sample     (in_chan.data.sample_value),
        .seed       (cfg_chan.data.seed_value),
        .left_value (cell_value[i-1]),
        .left_gt    (cell_gt[i-1]),
        .left_valid (cell_valid[i-1]),
        .value      (cell_value[i]),
        .gt         (cell_gt[i]),
        .valid      (cell_valid[i])
      );
    end
  end

  // median of the updated store
  rms_median #(.STORE_DEPTH(STORE_DEPTH)) u_median (
    .entries (cell_value),
    .count   (count_r),
    .median  (median)
  );

  // held count, restart to one entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= CW'(1);
    end else if (ctl.restart) begin
      count_r <= CW'(1);
    end else if (ctl.insert) begin
      count_r <= count_r + CW'(1);
    end
  end

  // median step pending after an accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else if (in_fire && !cfg_fire) begin
      pend_r <= 1'b1;
    end else if (out_load) begin
      pend_r <= 1'b0;
    end
  end

  // remember whether the word was dropped
  always_ff @(posedge clk) begin
    if (in_fire) begin
      drop_r <= full;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  // held count reported modulo 128
  assign count_ext = {{CountW{1'b0}}, count_r};

  // output register word
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_word_r.median_value <= median;
      out_word_r.held_count   <= count_ext[CountW-1:0];
      out_word_r.dropped      <= drop_r;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_word_r;

endmodule : running_median_sorted_store
`default_nettype wire
